/* rtl/pla_pkg.sv */
`default_nettype none

package pla_pkg;

    localparam int unsigned IDX_W = 8;
    localparam int unsigned COMP_W = 8;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic              mode;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [IDX_W-1:0]  read_index;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] entry_red;
        logic [COMP_W-1:0] entry_green;
        logic [COMP_W-1:0] entry_blue;
        logic              matched;
    } t_rsp;

    // Query broadcast to every cell while a token travels down the chain.
    typedef struct packed {
        logic             rd_mode;
        logic             search_en;
        t_rgb             rgb;
        logic [IDX_W-1:0] read_index;
    } t_query;

    // Write broadcast; only the cell whose index equals addr takes it.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_rgb             rgb;
    } t_wr;

    // Token handed from cell to cell, carrying the first hit seen so far.
    typedef struct packed {
        logic             live;
        logic             hit;
        logic [IDX_W-1:0] idx;
        t_rgb             rgb;
    } t_token;

endpackage

`default_nettype wire

/* rtl/pla_cell.sv */
`default_nettype none

module pla_cell
    import pla_pkg::*;
#(
    parameter int unsigned CELL_IDX   = 0,
    parameter bit          SEARCHABLE = 1'b1
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_query i_query,
    input  wire t_wr    i_wr,
    input  wire t_token i_tok,
    output t_token      o_tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    t_rgb   r_entry;
    t_rgb   n_entry;
    t_token r_tok;
    t_token n_tok;
    logic   match;

    // A read matches on the index alone; a lookup matches on the stored colour.
    always_comb begin
        if (i_query.rd_mode) begin
            match = (i_query.read_index == MY_IDX);
        end else begin
            match = i_query.search_en && SEARCHABLE && (r_entry == i_query.rgb);
        end
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.live && !i_tok.hit && match) begin
            n_tok.hit = 1'b1;
            n_tok.idx = MY_IDX;
            n_tok.rgb = r_entry;
        end
    end

    always_comb begin
        n_entry = r_entry;
        if (i_wr.en && (i_wr.addr == MY_IDX)) begin
            n_entry = i_wr.rgb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
            r_tok   <= '0;
        end else begin
            r_entry <= n_entry;
            r_tok   <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

/* rtl/palette_lookup_or_allocate.sv */
`default_nettype none

// Palette lookup-or-allocate. The palette lives in a row of PALETTE_ENTRIES
// cells, one colour per cell, all cleared to black at reset. A request in
// mode 0 carries a colour: once the allocation pointer has reached
// FIXED_ENTRIES, a token walks the row from cell 0 upward, one cell per
// clock, and the lowest cell holding that colour claims it (the last cell is
// never searched). On a miss, or while the pointer is still below
// FIXED_ENTRIES, the colour is written at the pointer, whose index is
// returned, and the pointer advances, wrapping from PALETTE_ENTRIES back to
// RECYCLE_BASE (to zero if RECYCLE_BASE is not below PALETTE_ENTRIES). A
// request in mode 1 reads back the entry at read_index, giving black for an
// index beyond the palette. The response is formed once the token has
// walked the whole row and its result is registered, and it waits in the
// output register until taken. One request is worked at a time, and a new
// one is accepted as soon as the previous response sits in the output
// register.

module palette_lookup_or_allocate
    import pla_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256,
    parameter int unsigned FIXED_ENTRIES   = 64,
    parameter int unsigned RECYCLE_BASE    = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] WRAP_TARGET =
        (RECYCLE_BASE < PALETTE_ENTRIES) ? IDX_W'(RECYCLE_BASE) : '0;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    t_query           r_query;
    t_query           n_query;
    logic             r_launch;
    t_token           r_result;
    t_token           n_result;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] n_ptr;
    logic             r_rsp_valid;
    logic             n_rsp_valid;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             req_fire;
    logic             rsp_load;
    logic [IDX_W:0]   ptr_inc;
    t_wr              wr;
    t_token           tok_chain [PALETTE_ENTRIES+1];

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;

    // The finished transaction moves to the output register once that
    // register is empty or being emptied in the same cycle.
    assign rsp_load = (r_state == ST_FINISH) && (!r_rsp_valid || i_rsp_ready);

    // The token enters cell 0 in the cycle after acceptance, when the query
    // register already holds the request.
    assign tok_chain[0] = t_token'({r_launch, {($bits(t_token) - 1){1'b0}}});

    for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
        pla_cell #(
            .CELL_IDX   (g),
            .SEARCHABLE (g != PALETTE_ENTRIES - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_query (r_query),
            .i_wr    (wr),
            .i_tok   (tok_chain[g]),
            .o_tok   (tok_chain[g+1])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_query  = r_query;
        n_result = r_result;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    n_query.rd_mode    = i_req.mode;
                    n_query.search_en  = (r_ptr >= IDX_W'(FIXED_ENTRIES));
                    n_query.rgb.red    = i_req.red;
                    n_query.rgb.green  = i_req.green;
                    n_query.rgb.blue   = i_req.blue;
                    n_query.read_index = i_req.read_index;
                    n_state            = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (tok_chain[PALETTE_ENTRIES].live) begin
                    n_result = tok_chain[PALETTE_ENTRIES];
                    n_state  = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (rsp_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Response forming, and allocation when a lookup missed or was skipped.
    assign ptr_inc = {1'b0, r_ptr} + 1'b1;

    always_comb begin
        n_rsp       = r_rsp;
        n_ptr       = r_ptr;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        wr          = '0;
        wr.addr     = r_ptr;
        wr.rgb      = r_query.rgb;
        if (rsp_load) begin
            n_rsp_valid = 1'b1;
            n_rsp.matched = 1'b0;
            if (r_query.rd_mode) begin
                n_rsp.entry_index = r_query.read_index;
                n_rsp.entry_red   = r_result.hit ? r_result.rgb.red   : '0;
                n_rsp.entry_green = r_result.hit ? r_result.rgb.green : '0;
                n_rsp.entry_blue  = r_result.hit ? r_result.rgb.blue  : '0;
            end else begin
                n_rsp.entry_red   = r_query.rgb.red;
                n_rsp.entry_green = r_query.rgb.green;
                n_rsp.entry_blue  = r_query.rgb.blue;
                if (r_result.hit) begin
                    n_rsp.entry_index = r_result.idx;
                    n_rsp.matched     = 1'b1;
                end else begin
                    n_rsp.entry_index = r_ptr;
                    wr.en             = 1'b1;
                    if (ptr_inc >= (IDX_W+1)'(PALETTE_ENTRIES)) begin
                        n_ptr = WRAP_TARGET;
                    end else begin
                        n_ptr = ptr_inc[IDX_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_launch    <= 1'b0;
            r_ptr       <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= req_fire;
            r_ptr       <= n_ptr;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query  <= n_query;
        r_result <= n_result;
        r_rsp    <= n_rsp;
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

`default_nettype wire
